/* rtl/rmqs_pkg.sv */
// Shared types, constants and the sequencer microcode ROM for the RGB matrix scanner.
// No dependencies; the interfaces and the top level take their names from here.
`timescale 1ns / 1ps
`default_nettype none

package rmqs_pkg;

   // Matrix geometry.
   localparam int ROW_COUNT   = 8;
   localparam int COL_COUNT   = 8;
   localparam int PIXEL_COUNT = ROW_COUNT * COL_COUNT;
   localparam int ROW_W       = $clog2(ROW_COUNT);
   localparam int COL_W       = $clog2(COL_COUNT);
   localparam int INDEX_W     = $clog2(PIXEL_COUNT);
   localparam int COUNT_W     = $clog2(PIXEL_COUNT + 1);

   // Field widths.
   localparam int CHAN_W  = 8;
   localparam int BYTE_W  = 8;
   localparam int SUM_W   = CHAN_W + 2;
   localparam int PROD_W  = 2 * CHAN_W;
   localparam int WIDE_W  = SUM_W + CHAN_W;

   // Threshold register reset value and the 3 * 255 scale of the mean.
   localparam logic [CHAN_W-1:0] THRESHOLD_RESET = 8'd20;
   localparam logic [SUM_W-1:0]  MEAN_SCALE      = 10'd765;

   // Bit positions of the colors in one stored pixel.
   localparam logic [1:0] LIT_RED   = 2'd0;
   localparam logic [1:0] LIT_GREEN = 2'd1;
   localparam logic [1:0] LIT_BLUE  = 2'd2;

   // Frame slots, in the order they go out within a row.
   localparam logic [1:0] SLOT_RED   = 2'd0;
   localparam logic [1:0] SLOT_BLUE  = 2'd1;
   localparam logic [1:0] SLOT_GREEN = 2'd2;

   // Request actions.
   localparam logic ACTION_WRITE   = 1'b0;
   localparam logic ACTION_REFRESH = 1'b1;

   // Program counter and named entry points.
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_IDLE    = 3'd0;
   localparam logic [STEP_W-1:0] STEP_MUL     = 3'd1;
   localparam logic [STEP_W-1:0] STEP_STORE   = 3'd2;
   localparam logic [STEP_W-1:0] STEP_READ    = 3'd3;
   localparam logic [STEP_W-1:0] STEP_EMIT_R  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT_B  = 3'd5;
   localparam logic [STEP_W-1:0] STEP_EMIT_G  = 3'd6;

   // Datapath operation of one step.
   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_MUL   = 3'd1,
      OP_STORE = 3'd2,
      OP_READ  = 3'd3,
      OP_EMIT  = 3'd4
   } op_type;

   // How the step counter moves on.
   typedef enum logic [1:0] {
      SEQ_NEXT     = 2'd0,
      SEQ_DISPATCH = 2'd1,
      SEQ_GOTO     = 2'd2,
      SEQ_LOOP     = 2'd3
   } seq_type;

   // One control word.
   typedef struct packed {
      op_type            op;
      seq_type           seq;
      logic [1:0]        slot;
      logic [1:0]        lit_bit;
      logic [STEP_W-1:0] target;
   } ucode_type;

   // One stored row: three lit bits for each column.
   typedef logic [COL_COUNT-1:0][2:0] row_word_type;

   // Microcode ROM. A pixel write runs multiply then store; a refresh runs
   // read and three emits per row, looping back until the last row.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] pc);
      ucode_type w;
      w = '{op: OP_IDLE, seq: SEQ_GOTO, slot: SLOT_RED, lit_bit: LIT_RED, target: STEP_IDLE};
      unique case (pc)
         STEP_IDLE:   w = '{OP_IDLE,  SEQ_DISPATCH, SLOT_RED,   LIT_RED,   STEP_IDLE};
         STEP_MUL:    w = '{OP_MUL,   SEQ_NEXT,     SLOT_RED,   LIT_RED,   STEP_STORE};
         STEP_STORE:  w = '{OP_STORE, SEQ_GOTO,     SLOT_RED,   LIT_RED,   STEP_IDLE};
         STEP_READ:   w = '{OP_READ,  SEQ_NEXT,     SLOT_RED,   LIT_RED,   STEP_EMIT_R};
         STEP_EMIT_R: w = '{OP_EMIT,  SEQ_NEXT,     SLOT_RED,   LIT_RED,   STEP_EMIT_B};
         STEP_EMIT_B: w = '{OP_EMIT,  SEQ_NEXT,     SLOT_BLUE,  LIT_BLUE,  STEP_EMIT_G};
         STEP_EMIT_G: w = '{OP_EMIT,  SEQ_LOOP,     SLOT_GREEN, LIT_GREEN, STEP_READ};
         default:     w = '{OP_IDLE,  SEQ_GOTO,     SLOT_RED,   LIT_RED,   STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* rtl/rmqs_if.sv */
// Valid/ready channel interfaces for the scanner's requests and frames.
// Depends on rmqs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

// Request channel: pixel writes and refresh requests.
interface rmqs_req_if;
   logic                              valid;
   logic                              ready;
   logic                              action;
   logic [rmqs_pkg::INDEX_W-1:0]      pixel_index;
   logic [rmqs_pkg::CHAN_W-1:0]       red;
   logic [rmqs_pkg::CHAN_W-1:0]       green;
   logic [rmqs_pkg::CHAN_W-1:0]       blue;
   logic [rmqs_pkg::CHAN_W-1:0]       alpha;

   modport source (output valid, action, pixel_index, red, green, blue, alpha,
                   input ready);
   modport sink   (input valid, action, pixel_index, red, green, blue, alpha,
                   output ready);
endinterface

// Frame channel: one four-byte frame per transfer.
interface rmqs_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rmqs_pkg::BYTE_W-1:0]       frame_byte0;
   logic [rmqs_pkg::BYTE_W-1:0]       frame_byte1;
   logic [rmqs_pkg::BYTE_W-1:0]       frame_byte2;
   logic [rmqs_pkg::BYTE_W-1:0]       row_select;
   logic                              last_frame;
   logic                              any_lit;

   modport source (output valid, frame_byte0, frame_byte1, frame_byte2, row_select,
                   last_frame, any_lit, input ready);
   modport sink   (input valid, frame_byte0, frame_byte1, frame_byte2, row_select,
                   last_frame, any_lit, output ready);
endinterface

`default_nettype wire

/* rtl/rgb_matrix_quantize_scanner.sv */
// Top level of the 8x8 RGB matrix scanner: microcoded sequencer, pixel store and frame output.
// Depends on rmqs_pkg and the channel interfaces in rmqs_if.sv.
//
//   channel   | direction | handshake     | contents
//   ----------+-----------+---------------+-----------------------------------------
//   req_ch    | in        | valid/ready   | action, pixel_index, red, green, blue, alpha
//   rsp_ch    | out       | valid/ready   | three color bytes, row select, last, any lit
//   csr_*     | in        | write enable  | lit_threshold
//
// A pixel write runs accept, multiply, then compare and store.
// A refresh accepts the request and then, for each row, does the registered row read
// and emits one frame per color.
// Stalls on rsp_ch hold the sequencer on the emit step; the output register lets
// the next request be accepted while the final frame still waits.
// Reset clears the pixel valid flags at once, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module rgb_matrix_quantize_scanner (
   input  wire                              clock,
   input  wire                              reset,
   rmqs_req_if.sink                         req_ch,
   rmqs_rsp_if.source                       rsp_ch,
   input  wire                              csr_wr_en,
   input  wire [rmqs_pkg::CHAN_W-1:0]       csr_wr_data
);

   // Sequencer and control state.
   logic [rmqs_pkg::STEP_W-1:0]       pc_ff, pc_in;
   logic [rmqs_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [rmqs_pkg::CHAN_W-1:0]       thr_ff, thr_in;
   logic [rmqs_pkg::PIXEL_COUNT-1:0]  valid_ff, valid_in;
   logic [rmqs_pkg::PIXEL_COUNT-1:0]  nz_ff, nz_in;
   logic [rmqs_pkg::COUNT_W-1:0]      lit_count_ff, lit_count_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // Captured request and product registers.
   logic [rmqs_pkg::INDEX_W-1:0]      idx_ff;
   logic [rmqs_pkg::CHAN_W-1:0]       red_ff, green_ff, blue_ff, alpha_ff;
   logic [rmqs_pkg::WIDE_W-1:0]       sum_prod_ff, thr_prod_ff;
   logic [rmqs_pkg::PROD_W-1:0]       red_prod_ff, green_prod_ff, blue_prod_ff;

   // Pixel store and its registered read port.
   rmqs_pkg::row_word_type            row_mem [rmqs_pkg::ROW_COUNT];
   rmqs_pkg::row_word_type            rd_row_ff;
   logic [rmqs_pkg::COL_COUNT-1:0]    rd_valid_ff;

   // Output payload registers.
   logic [rmqs_pkg::BYTE_W-1:0]       byte0_ff, byte1_ff, byte2_ff, row_sel_ff;
   logic                              last_ff, any_ff;

   rmqs_pkg::ucode_type               uc;
   logic                              req_take;
   logic                              emit_go;
   logic                              adv;
   logic [rmqs_pkg::SUM_W-1:0]        chan_sum;
   logic                              pix_lit;
   logic [2:0]                        new_bits;
   logic [rmqs_pkg::BYTE_W-1:0]       col_byte;
   logic [rmqs_pkg::BYTE_W-1:0]       row_onehot;

   // Three times a product plus the mean slack, at the width of the sum product.
   function automatic logic [rmqs_pkg::WIDE_W-1:0] weigh(input logic [rmqs_pkg::PROD_W-1:0] p);
      logic [rmqs_pkg::WIDE_W-1:0] x;
      x = rmqs_pkg::WIDE_W'(p);
      return (x << 1) + x + rmqs_pkg::WIDE_W'(rmqs_pkg::MEAN_SCALE);
   endfunction

   // Current control word.
   assign uc       = rmqs_pkg::ucode_rom(pc_ff);
   assign req_take = req_ch.valid && req_ch.ready;
   assign emit_go  = (uc.op == rmqs_pkg::OP_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   assign adv      = (uc.op != rmqs_pkg::OP_EMIT) || emit_go;

   // Quantizer compare stage, working from the registered products.
   assign chan_sum = rmqs_pkg::SUM_W'(red_ff) + rmqs_pkg::SUM_W'(green_ff)
                   + rmqs_pkg::SUM_W'(blue_ff);
   assign pix_lit  = sum_prod_ff > thr_prod_ff;
   always_comb begin
      new_bits = 3'b000;
      if (pix_lit) begin
         new_bits[rmqs_pkg::LIT_RED]   = weigh(red_prod_ff)   >= sum_prod_ff;
         new_bits[rmqs_pkg::LIT_GREEN] = weigh(green_prod_ff) >= sum_prod_ff;
         new_bits[rmqs_pkg::LIT_BLUE]  = weigh(blue_prod_ff)  >= sum_prod_ff;
      end
   end

   // Active-low column byte of the selected color; column j drives bit 7-j.
   always_comb begin
      for (int j = 0; j < rmqs_pkg::COL_COUNT; j++) begin
         col_byte[rmqs_pkg::COL_COUNT-1-j] = ~(rd_valid_ff[j] & rd_row_ff[j][uc.lit_bit]);
      end
   end
   assign row_onehot = rmqs_pkg::BYTE_W'(1) << (rmqs_pkg::ROW_W'(rmqs_pkg::ROW_COUNT - 1) - row_ff);

   // Sequencer, threshold register, pixel flags and output register.
   always_comb begin
      pc_in        = pc_ff;
      row_in       = row_ff;
      thr_in       = thr_ff;
      valid_in     = valid_ff;
      nz_in        = nz_ff;
      lit_count_in = lit_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      if (csr_wr_en) begin
         thr_in = csr_wr_data;
      end

      // Pixel store bookkeeping: valid flag and count of non-dark pixels.
      if (uc.op == rmqs_pkg::OP_STORE) begin
         valid_in[idx_ff] = 1'b1;
         nz_in[idx_ff]    = |new_bits;
         lit_count_in     = lit_count_ff - rmqs_pkg::COUNT_W'(nz_ff[idx_ff])
                          + rmqs_pkg::COUNT_W'(|new_bits);
      end

      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end

      // Step counter.
      case (uc.seq)
         rmqs_pkg::SEQ_DISPATCH: begin
            if (req_take) begin
               pc_in  = (req_ch.action == rmqs_pkg::ACTION_REFRESH) ?
                        rmqs_pkg::STEP_READ : rmqs_pkg::STEP_MUL;
               row_in = '0;
            end
         end
         rmqs_pkg::SEQ_GOTO: begin
            pc_in = uc.target;
         end
         rmqs_pkg::SEQ_LOOP: begin
            if (adv) begin
               row_in = row_ff + 1'b1;
               pc_in  = (row_ff == rmqs_pkg::ROW_W'(rmqs_pkg::ROW_COUNT - 1)) ?
                        rmqs_pkg::STEP_IDLE : uc.target;
            end
         end
         default: begin
            if (adv) begin
               pc_in = uc.target;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= rmqs_pkg::STEP_IDLE;
         row_ff       <= '0;
         thr_ff       <= rmqs_pkg::THRESHOLD_RESET;
         valid_ff     <= '0;
         nz_ff        <= '0;
         lit_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         row_ff       <= row_in;
         thr_ff       <= thr_in;
         valid_ff     <= valid_in;
         nz_ff        <= nz_in;
         lit_count_ff <= lit_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request capture and the multiply stage.
   always_ff @(posedge clock) begin
      if (req_take) begin
         idx_ff   <= req_ch.pixel_index;
         red_ff   <= req_ch.red;
         green_ff <= req_ch.green;
         blue_ff  <= req_ch.blue;
         alpha_ff <= req_ch.alpha;
      end
      if (uc.op == rmqs_pkg::OP_MUL) begin
         sum_prod_ff   <= rmqs_pkg::WIDE_W'(chan_sum) * rmqs_pkg::WIDE_W'(alpha_ff);
         thr_prod_ff   <= rmqs_pkg::WIDE_W'(rmqs_pkg::MEAN_SCALE) * rmqs_pkg::WIDE_W'(thr_ff);
         red_prod_ff   <= rmqs_pkg::PROD_W'(red_ff)   * rmqs_pkg::PROD_W'(alpha_ff);
         green_prod_ff <= rmqs_pkg::PROD_W'(green_ff) * rmqs_pkg::PROD_W'(alpha_ff);
         blue_prod_ff  <= rmqs_pkg::PROD_W'(blue_ff)  * rmqs_pkg::PROD_W'(alpha_ff);
      end
   end

   // Pixel store: one pixel written, one row read, read data registered.
   always_ff @(posedge clock) begin
      if (uc.op == rmqs_pkg::OP_STORE) begin
         row_mem[idx_ff[rmqs_pkg::INDEX_W-1:rmqs_pkg::COL_W]]
                [idx_ff[rmqs_pkg::COL_W-1:0]] <= new_bits;
      end
      if (uc.op == rmqs_pkg::OP_READ) begin
         rd_row_ff   <= row_mem[row_ff];
         rd_valid_ff <= valid_ff[{row_ff, rmqs_pkg::COL_W'(0)} +: rmqs_pkg::COL_COUNT];
      end
   end

   // Frame payload register.
   always_ff @(posedge clock) begin
      if (emit_go) begin
         byte0_ff   <= (uc.slot == rmqs_pkg::SLOT_RED)   ? col_byte : '1;
         byte1_ff   <= (uc.slot == rmqs_pkg::SLOT_BLUE)  ? col_byte : '1;
         byte2_ff   <= (uc.slot == rmqs_pkg::SLOT_GREEN) ? col_byte : '1;
         row_sel_ff <= row_onehot;
         last_ff    <= (uc.seq == rmqs_pkg::SEQ_LOOP) &&
                       (row_ff == rmqs_pkg::ROW_W'(rmqs_pkg::ROW_COUNT - 1));
         any_ff     <= lit_count_ff != '0;
      end
   end

   // Port drive.
   assign req_ch.ready       = uc.op == rmqs_pkg::OP_IDLE;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.frame_byte0 = byte0_ff;
   assign rsp_ch.frame_byte1 = byte1_ff;
   assign rsp_ch.frame_byte2 = byte2_ff;
   assign rsp_ch.row_select  = row_sel_ff;
   assign rsp_ch.last_frame  = last_ff;
   assign rsp_ch.any_lit     = any_ff;

endmodule

`default_nettype wire
